/* src/gclp_pkg.sv */
// ----------------------------------------------------------------------------
// gclp_pkg: shared constants and types for the letter path engine
// Grid limits, field widths, register codes and the control bundles that
// pass between the sequencer and the column cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gclp_pkg;

	// Grid limits
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;

	// Derived widths
	localparam int ROW_AW = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int POS_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
	localparam int STEP_W = $clog2(MAX_ROWS + 2);

	// Fixed field widths
	localparam int CFG_W  = 7;
	localparam int CHAR_W = 8;
	localparam int LEN_W  = 8;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Path starts at this byte; a path can hold at most 256 - 'A' levels
	localparam logic [CHAR_W-1:0] LETTER_A   = 8'd65;
	localparam logic [LEN_W-1:0]  MAX_LEVELS = LEN_W'(256 - 65);

	// Register index codes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// One grid cell write during loading
	typedef struct packed {
		logic             we;
		logic [COL_W-1:0]  bank;
		logic [ROW_AW-1:0] addr;
	} gclp_load_t;

	// Row base used to fetch one grid row from the linear banks
	typedef struct packed {
		logic [COL_W-1:0]  base_bank;
		logic [ROW_AW-1:0] base_addr;
		logic [COL_W-1:0]  rot;
	} gclp_read_t;

	// Per-cycle control broadcast to every column cell during a sweep
	typedef struct packed {
		logic              shift;
		logic              clear;
		logic              wr_en;
		logic              first;
		logic              rd_valid;
		logic              rd_bank;
		logic              wr_bank;
		logic [ROW_AW-1:0] rd_row;
		logic [ROW_AW-1:0] wr_row;
		logic [CHAR_W-1:0] target;
	} gclp_sweep_t;

endpackage

/* src/gclp_ram.sv */
// ----------------------------------------------------------------------------
// gclp_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gclp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* src/gclp_cell.sv */
// ----------------------------------------------------------------------------
// gclp_cell: one grid column of the frontier engine
// Holds the column's frontier bits in two banks, keeps a three-row window
// and decides the column's next-level bit for the row in the middle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gclp_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gclp_pkg::gclp_sweep_t        ctl,
	input  logic                         col_ok,
	input  logic [gclp_pkg::CHAR_W-1:0]  char_in,
	input  logic                         left_in,
	input  logic                         right_in,
	output logic                         col_or,
	output logic                         hit
);

	logic                        fr_rd;
	logic                        next_bit;
	logic                        prev_q;
	logic                        cur_q;
	logic [gclp_pkg::CHAR_W-1:0] char_q;
	logic                        touch;
	logic                        new_bit;

	// Frontier store: old level in one bank, new level in the other
	gclp_ram #(
		.DEPTH(2 * gclp_pkg::MAX_ROWS),
		.WIDTH(1)
	) u_fr_ram (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr({ctl.wr_bank, ctl.wr_row}),
		.wdata(new_bit),
		.raddr({ctl.rd_bank, ctl.rd_row}),
		.rdata(fr_rd)
	);

	// Rows past the bottom edge read as empty
	assign next_bit = fr_rd & ctl.rd_valid;

	// Column summary handed to both neighbors
	assign col_or = prev_q | cur_q | next_bit;

	// Any of the 8 neighbors on the old frontier
	assign touch = left_in | right_in | prev_q | next_bit;

	// Next-level bit for the middle row of the window
	assign new_bit = col_ok && (char_q == ctl.target) && (ctl.first || touch);
	assign hit     = new_bit & ctl.wr_en;

	// Advance the window one row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			cur_q  <= 1'b0;
		end else if (ctl.clear) begin
			prev_q <= 1'b0;
			cur_q  <= 1'b0;
		end else if (ctl.shift) begin
			prev_q <= cur_q;
			cur_q  <= next_bit;
		end
	end

	// Hold the character of the row entering the window
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			char_q <= char_in;
		end
	end

endmodule

/* src/gclp_ctrl.sv */
// ----------------------------------------------------------------------------
// gclp_ctrl: load counter and level sequencer
// Tracks the raster load position, then runs one row sweep per level and
// counts the non-empty levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gclp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          last_cell,
	input  logic [gclp_pkg::CFG_W-1:0]    rows_cfg,
	input  logic [gclp_pkg::CFG_W-1:0]    cols_cfg,
	input  logic                          any_hit,
	output logic                          busy,
	output logic                          done,
	output logic [gclp_pkg::LEN_W-1:0]    path_length,
	output logic [gclp_pkg::COLS_W-1:0]   cols_eff,
	output gclp_pkg::gclp_load_t          ld,
	output gclp_pkg::gclp_read_t          rd,
	output gclp_pkg::gclp_sweep_t         ctl
);

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_SWEEP = 1'b1;
	localparam int   TOT_W    = gclp_pkg::ROWS_W + gclp_pkg::COLS_W;
	localparam int   SRC_W    = gclp_pkg::COL_W + 1;

	logic                          state_q;
	logic [gclp_pkg::ROWS_W-1:0]   rows_eff;
	logic [TOT_W-1:0]              total;
	logic [gclp_pkg::POS_W-1:0]    pos_q;
	logic [gclp_pkg::COL_W-1:0]    ld_bank_q;
	logic [gclp_pkg::ROW_AW-1:0]   ld_addr_q;
	logic [gclp_pkg::STEP_W-1:0]   step_q;
	logic [gclp_pkg::COL_W-1:0]    base_bank_q;
	logic [gclp_pkg::ROW_AW-1:0]   base_addr_q;
	logic [gclp_pkg::COL_W-1:0]    rot_q;
	logic [gclp_pkg::LEN_W-1:0]    count_q;
	logic                          bank_q;
	logic                          any_q;
	logic                          rd_valid_q;
	logic                          done_q;
	logic [gclp_pkg::LEN_W-1:0]    len_q;
	logic                          accept;
	logic                          store;
	logic                          sweep_end;
	logic                          any_now;
	logic [gclp_pkg::LEN_W-1:0]    count_inc;
	logic [SRC_W-1:0]              base_sum;

	// Clamp the size registers into range
	always_comb begin
		if (rows_cfg == '0) begin
			rows_eff = gclp_pkg::ROWS_W'(1);
		end else if (int'(rows_cfg) > gclp_pkg::MAX_ROWS) begin
			rows_eff = gclp_pkg::ROWS_W'(gclp_pkg::MAX_ROWS);
		end else begin
			rows_eff = gclp_pkg::ROWS_W'(rows_cfg);
		end
		if (cols_cfg == '0) begin
			cols_eff = gclp_pkg::COLS_W'(1);
		end else if (int'(cols_cfg) > gclp_pkg::MAX_COLS) begin
			cols_eff = gclp_pkg::COLS_W'(gclp_pkg::MAX_COLS);
		end else begin
			cols_eff = gclp_pkg::COLS_W'(cols_cfg);
		end
	end

	assign total  = TOT_W'(rows_eff) * TOT_W'(cols_eff);
	assign accept = start && (state_q == ST_LOAD);
	assign store  = accept && (TOT_W'(pos_q) < total);

	// Cell writes go to the linear banks
	assign ld.we   = store;
	assign ld.bank = ld_bank_q;
	assign ld.addr = ld_addr_q;

	// Row base and the rotation that lines the fetched row up by column
	assign rd.base_bank = base_bank_q;
	assign rd.base_addr = base_addr_q;
	assign rd.rot       = rot_q;
	assign base_sum     = SRC_W'(base_bank_q) + SRC_W'(cols_eff);

	// Sweep control broadcast
	assign ctl.shift    = (state_q == ST_SWEEP);
	assign ctl.clear    = (step_q == '0);
	assign ctl.wr_en    = (state_q == ST_SWEEP) && (step_q >= gclp_pkg::STEP_W'(2));
	assign ctl.first    = (count_q == '0);
	assign ctl.rd_valid = rd_valid_q;
	assign ctl.rd_bank  = bank_q;
	assign ctl.wr_bank  = ~bank_q;
	assign ctl.rd_row   = step_q[gclp_pkg::ROW_AW-1:0];
	assign ctl.wr_row   = gclp_pkg::ROW_AW'(step_q - gclp_pkg::STEP_W'(2));
	assign ctl.target   = gclp_pkg::LETTER_A + count_q;

	assign sweep_end = (step_q == gclp_pkg::STEP_W'(rows_eff) + gclp_pkg::STEP_W'(1));
	assign any_now   = any_q | any_hit;
	assign count_inc = count_q + gclp_pkg::LEN_W'(1);

	assign busy        = (state_q == ST_SWEEP);
	assign done        = done_q;
	assign path_length = len_q;

	// Load position and sweep sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			pos_q       <= '0;
			ld_bank_q   <= '0;
			ld_addr_q   <= '0;
			step_q      <= '0;
			base_bank_q <= '0;
			base_addr_q <= '0;
			rot_q       <= '0;
			count_q     <= '0;
			bank_q      <= 1'b0;
			any_q       <= 1'b0;
			rd_valid_q  <= 1'b0;
			done_q      <= 1'b0;
			len_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					// advance the raster position on each stored cell
					if (store) begin
						pos_q <= pos_q + gclp_pkg::POS_W'(1);
						if (ld_bank_q == gclp_pkg::COL_W'(gclp_pkg::MAX_COLS - 1)) begin
							ld_bank_q <= '0;
							ld_addr_q <= ld_addr_q + gclp_pkg::ROW_AW'(1);
						end else begin
							ld_bank_q <= ld_bank_q + gclp_pkg::COL_W'(1);
						end
					end
					// final cell: rewind the load position and start level one
					if (accept && last_cell) begin
						state_q     <= ST_SWEEP;
						pos_q       <= '0;
						ld_bank_q   <= '0;
						ld_addr_q   <= '0;
						step_q      <= '0;
						base_bank_q <= '0;
						base_addr_q <= '0;
						count_q     <= '0;
						any_q       <= 1'b0;
					end
				end
				ST_SWEEP: begin
					rd_valid_q <= (step_q < gclp_pkg::STEP_W'(rows_eff));
					rot_q      <= base_bank_q;
					// step the row base by one grid row
					if (base_sum >= SRC_W'(gclp_pkg::MAX_COLS)) begin
						base_bank_q <= gclp_pkg::COL_W'(base_sum - SRC_W'(gclp_pkg::MAX_COLS));
						base_addr_q <= base_addr_q + gclp_pkg::ROW_AW'(1);
					end else begin
						base_bank_q <= gclp_pkg::COL_W'(base_sum);
					end
					if (sweep_end) begin
						step_q      <= '0;
						base_bank_q <= '0;
						base_addr_q <= '0;
						any_q       <= 1'b0;
						if (!any_now) begin
							// empty level ends the path
							state_q <= ST_LOAD;
							done_q  <= 1'b1;
							len_q   <= count_q;
						end else if (count_inc == gclp_pkg::MAX_LEVELS) begin
							// byte range exhausted
							state_q <= ST_LOAD;
							done_q  <= 1'b1;
							len_q   <= count_inc;
						end else begin
							count_q <= count_inc;
							bank_q  <= ~bank_q;
						end
					end else begin
						step_q <= step_q + gclp_pkg::STEP_W'(1);
						any_q  <= any_now;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

/* src/grid_consecutive_letter_path.sv */
// ----------------------------------------------------------------------------
// grid_consecutive_letter_path: longest consecutive letter path on a grid
// Loads a grid one cell per accepted start, then grows the frontier of
// consecutive bytes from every 'A' and reports the number of levels.
// Throughput: one grid cell per cycle while loading (busy stays low).
// After the last cell, each level is a row sweep through the column cell
// chain; the sweeps are capped at 191, and done pulses once together with
// path_length.
// Reset clears the load position, level count and sequencer; grid storage
// holds no reset state. The receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_consecutive_letter_path (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [gclp_pkg::CHAR_W-1:0]       cell_char,
	input  logic                              last_cell,
	output logic                              done,
	output logic [gclp_pkg::LEN_W-1:0]        path_length,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gclp_pkg::ADDR_W-1:0]       paddr,
	input  logic [gclp_pkg::DATA_W-1:0]       pwdata,
	output logic [gclp_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	localparam int SRC_W = gclp_pkg::COL_W + 1;

	logic [gclp_pkg::CFG_W-1:0]   rows_q;
	logic [gclp_pkg::CFG_W-1:0]   cols_q;
	logic                         cfg_wr;
	logic [gclp_pkg::COLS_W-1:0]  cols_eff;
	gclp_pkg::gclp_load_t         ld;
	gclp_pkg::gclp_read_t         rd;
	gclp_pkg::gclp_sweep_t        ctl;
	logic [gclp_pkg::CHAR_W-1:0]  bank_rd  [gclp_pkg::MAX_COLS];
	logic [gclp_pkg::CHAR_W-1:0]  char_col [gclp_pkg::MAX_COLS];
	logic [gclp_pkg::MAX_COLS-1:0] col_or;
	logic [gclp_pkg::MAX_COLS-1:0] hit;
	logic [SRC_W-1:0]             src;

	// Register transfer on the configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gclp_pkg::CFG_W'(1);
			cols_q <= gclp_pkg::CFG_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				gclp_pkg::REG_ROWS: rows_q <= pwdata[gclp_pkg::CFG_W-1:0];
				gclp_pkg::REG_COLS: cols_q <= pwdata[gclp_pkg::CFG_W-1:0];
				default:            rows_q <= rows_q;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (paddr[2])
			gclp_pkg::REG_ROWS: prdata = gclp_pkg::DATA_W'(rows_q);
			gclp_pkg::REG_COLS: prdata = gclp_pkg::DATA_W'(cols_q);
			default:            prdata = '0;
		endcase
	end

	gclp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_cell  (last_cell),
		.rows_cfg   (rows_q),
		.cols_cfg   (cols_q),
		.any_hit    (|hit),
		.busy       (busy),
		.done       (done),
		.path_length(path_length),
		.cols_eff   (cols_eff),
		.ld         (ld),
		.rd         (rd),
		.ctl        (ctl)
	);

	// Rotate the fetched banks so that entry c holds grid column c
	always_comb begin
		src = '0;
		for (int c = 0; c < gclp_pkg::MAX_COLS; c++) begin
			src = SRC_W'(rd.rot) + SRC_W'(c);
			if (src >= SRC_W'(gclp_pkg::MAX_COLS)) begin
				src = src - SRC_W'(gclp_pkg::MAX_COLS);
			end
			char_col[c] = bank_rd[src[gclp_pkg::COL_W-1:0]];
		end
	end

	for (genvar j = 0; j < gclp_pkg::MAX_COLS; j++) begin : g_col
		logic                        bank_we;
		logic [gclp_pkg::ROW_AW-1:0] bank_ra;
		logic                        left_in;
		logic                        right_in;

		// Linear grid storage, one bank per raster position modulo MAX_COLS
		assign bank_we = ld.we && (ld.bank == gclp_pkg::COL_W'(j));
		assign bank_ra = rd.base_addr +
			gclp_pkg::ROW_AW'(gclp_pkg::COL_W'(j) < rd.base_bank);

		gclp_ram #(
			.DEPTH(gclp_pkg::MAX_ROWS),
			.WIDTH(gclp_pkg::CHAR_W)
		) u_bank (
			.clk  (clk),
			.we   (bank_we),
			.waddr(ld.addr),
			.wdata(cell_char),
			.raddr(bank_ra),
			.rdata(bank_rd[j])
		);

		// Neighbor links along the chain
		if (j > 0) begin : g_left
			assign left_in = col_or[j-1];
		end else begin : g_left_edge
			assign left_in = 1'b0;
		end
		if (j < gclp_pkg::MAX_COLS - 1) begin : g_right
			assign right_in = col_or[j+1];
		end else begin : g_right_edge
			assign right_in = 1'b0;
		end

		gclp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.col_ok  (gclp_pkg::COLS_W'(j) < cols_eff),
			.char_in (char_col[j]),
			.left_in (left_in),
			.right_in(right_in),
			.col_or  (col_or[j]),
			.hit     (hit[j])
		);
	end

endmodule

/* src/gclp_checker.sv */
// ----------------------------------------------------------------------------
// gclp_checker: port-level checks for the letter path engine
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gclp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        last_cell,
	input logic                        done,
	input logic [gclp_pkg::LEN_W-1:0]  path_length
);

	// A result closes the evaluation
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// A result follows an evaluation
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding evaluation");

	// Evaluation starts only on a final cell transfer
	a_busy_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last_cell && !busy))
		else $error("evaluation started without a final cell");

	// Path length stays within the byte range above 'A'
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (path_length <= gclp_pkg::MAX_LEVELS))
		else $error("path length out of range");

endmodule

bind grid_consecutive_letter_path gclp_checker u_gclp_checker (.*);
